FILE: rtl/idw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idw_pkg
// Shared types and codes for the inverse-distance elevation interpolator.
// ----------------------------------------------------------------------------
package idw_pkg;

  localparam logic       KIND_LOAD      = 1'b0;
  localparam logic       KIND_QUERY     = 1'b1;

  localparam logic [1:0] STATUS_INTERP  = 2'd0;
  localparam logic [1:0] STATUS_HIT     = 2'd1;
  localparam logic [1:0] STATUS_EMPTY   = 2'd2;

  // configuration register index (paddr[2])
  localparam logic       REG_POINT_COUNT = 1'b0;

  localparam logic [62:0] W_MAX   = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] D2_HALF = 64'h8000_0000_0000_0000;
  localparam logic [31:0] POS_SAT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_SAT = 32'h8000_0000;

  typedef struct packed {
    logic load_wr;   // write table slot from input beat
    logic q_latch;   // capture query, clear sums
    logic rd;        // read table entry i
    logic diff;      // abs differences
    logic sqr;       // squares
    logic sum;       // squared distance
    logic div_rcp;   // start 2^63 / d2
    logic wgt;       // form weight
    logic mlo;       // low partial product
    logic mhi;       // accumulate low, high partial product
    logic macc;      // accumulate high, weight sum
    logic nxt;       // advance point index
    logic div_fin;   // start final division
    logic res_hit;   // load result: exact hit
    logic res_empty; // load result: empty table
    logic res_fin;   // load result: interpolated
  } cmd_t;

  typedef struct packed {
    logic empty;     // effective point count is zero
    logic hit;       // d2 == 0
    logic far;       // weight saturates to 1
    logic last;      // current index is the last point
    logic div_busy;
    logic out_busy;  // result register full and not taken this cycle
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/idw_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idw_in_if
// Input channel: load or query beats.
// ----------------------------------------------------------------------------
interface idw_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [3:0]         slot;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] height;

  modport source (output valid, kind, slot, coord_x, coord_y, height, input ready);
  modport sink   (input valid, kind, slot, coord_x, coord_y, height, output ready);
endinterface
`default_nettype wire

FILE: rtl/idw_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idw_out_if
// Output channel: interpolated elevation and status.
// ----------------------------------------------------------------------------
interface idw_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] elevation_out;
  logic [1:0]         status;

  modport source (output valid, elevation_out, status, input ready);
  modport sink   (input valid, elevation_out, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/idw_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idw_div
// Restoring divider, one quotient bit per cycle, MSB-first over num.
// Keeps the low 64 quotient bits.
// ----------------------------------------------------------------------------
module idw_div #(
  parameter int NUM_W = 99,
  parameter int DEN_W = 68,
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [CNT_W-1:0] iters,
  output logic             busy,
  output logic [63:0]      quo
);

  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem, num_sh[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign ge      = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= iters;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      den_r  <= den;
      rem    <= '0;
      quo    <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      rem    <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo    <= {quo[62:0], ge};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/idw_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idw_dp
// Datapath: point tables, distance and weight arithmetic, sums, result reg.
// ----------------------------------------------------------------------------
module idw_dp #(
  parameter int MAX_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  idw_pkg::cmd_t      cmd,
  output idw_pkg::sts_t      sts,
  input  logic [4:0]         point_count,
  input  logic [3:0]         slot,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] elevation_out,
  output logic [1:0]         status
);
  import idw_pkg::*;

  localparam int IW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW    = IW + 1;
  localparam int ACC_W = 95 + IW;
  localparam int DEN_W = 64 + IW;
  localparam int CNT_W = $clog2(ACC_W + 1);

  logic [31:0] mem_x [MAX_POINTS];
  logic [31:0] mem_y [MAX_POINTS];
  logic [31:0] mem_h [MAX_POINTS];

  logic [31:0]      qx, qy, tx, ty, th;
  logic [CW-1:0]    n, i;
  logic [31:0]      adx, ady, hm;
  logic             hneg;
  logic [63:0]      sx, sy, mp;
  logic [64:0]      d2;
  logic [62:0]      w;
  logic [ACC_W-1:0] pos, neg;
  logic [DEN_W-1:0] wsum;
  logic             sgn;

  logic [8:0]       slot_ext, pc_ext, n_sat;
  logic             slot_ok;
  logic [CW-1:0]    n_calc;
  logic [32:0]      dx, dy;
  logic             far;
  logic             pos_ge;
  logic [ACC_W-1:0] num_fin;
  logic             div_start, div_busy;
  logic [ACC_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [CNT_W-1:0] div_iters;
  logic [63:0]      quo;

  assign slot_ext = {5'b0, slot};
  assign slot_ok  = slot_ext < 9'(MAX_POINTS);
  assign pc_ext   = {4'b0, point_count};
  assign n_sat    = (pc_ext > 9'(MAX_POINTS)) ? 9'(MAX_POINTS) : pc_ext;
  assign n_calc   = n_sat[CW-1:0];

  assign dx  = {qx[31], qx} - {tx[31], tx};
  assign dy  = {qy[31], qy} - {ty[31], ty};
  assign far = d2[64] || (d2[63:0] > D2_HALF);

  assign pos_ge  = pos >= neg;
  assign num_fin = pos_ge ? (pos - neg) : (neg - pos);

  assign div_start = cmd.div_rcp || cmd.div_fin;
  assign div_num   = cmd.div_fin ? num_fin : {1'b1, {(ACC_W-1){1'b0}}};
  assign div_den   = cmd.div_fin ? wsum : DEN_W'(d2[63:0]);
  assign div_iters = cmd.div_fin ? CNT_W'(ACC_W) : CNT_W'(64);

  idw_div #(
    .NUM_W (ACC_W),
    .DEN_W (DEN_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .iters (div_iters),
    .busy  (div_busy),
    .quo   (quo)
  );

  // point tables
  always_ff @(posedge clk) begin
    if (cmd.load_wr && slot_ok) begin
      mem_x[slot_ext[IW-1:0]] <= coord_x;
      mem_y[slot_ext[IW-1:0]] <= coord_y;
      mem_h[slot_ext[IW-1:0]] <= height;
    end
    if (cmd.rd) begin
      tx <= mem_x[i[IW-1:0]];
      ty <= mem_y[i[IW-1:0]];
      th <= mem_h[i[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
      i <= '0;
    end else if (cmd.q_latch) begin
      n <= n_calc;
      i <= '0;
    end else if (cmd.nxt) begin
      i <= i + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_latch) begin
      qx   <= coord_x;
      qy   <= coord_y;
      pos  <= '0;
      neg  <= '0;
      wsum <= '0;
    end
    if (cmd.diff) begin
      adx  <= dx[32] ? 32'(-dx) : dx[31:0];
      ady  <= dy[32] ? 32'(-dy) : dy[31:0];
      hneg <= th[31];
      hm   <= th[31] ? (~th + 32'd1) : th;
    end
    if (cmd.sqr) begin
      sx <= adx * adx;
      sy <= ady * ady;
    end
    if (cmd.sum) begin
      d2 <= {1'b0, sx} + {1'b0, sy};
    end
    if (cmd.wgt) begin
      w <= far ? 63'd1 : (quo[63] ? W_MAX : quo[62:0]);
    end
    if (cmd.mlo) begin
      mp <= w[31:0] * hm;
    end
    if (cmd.mhi) begin
      if (hneg) begin
        neg <= neg + ACC_W'(mp);
      end else begin
        pos <= pos + ACC_W'(mp);
      end
      mp <= {1'b0, w[62:32]} * hm;
    end
    if (cmd.macc) begin
      if (hneg) begin
        neg <= neg + ACC_W'({mp, 32'b0});
      end else begin
        pos <= pos + ACC_W'({mp, 32'b0});
      end
      wsum <= wsum + DEN_W'(w);
    end
    if (cmd.div_fin) begin
      sgn <= !pos_ge;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_hit || cmd.res_empty || cmd.res_fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_hit) begin
      elevation_out <= th;
      status        <= STATUS_HIT;
    end else if (cmd.res_empty) begin
      elevation_out <= '0;
      status        <= STATUS_EMPTY;
    end else if (cmd.res_fin) begin
      status <= STATUS_INTERP;
      if (!sgn) begin
        elevation_out <= (quo > 64'(POS_SAT)) ? POS_SAT : quo[31:0];
      end else begin
        elevation_out <= (quo > 64'(NEG_SAT)) ? NEG_SAT : (~quo[31:0] + 32'd1);
      end
    end
  end

  assign sts.empty    = (n_calc == '0);
  assign sts.hit      = (d2 == '0);
  assign sts.far      = far;
  assign sts.last     = (CW'(i + 1'b1) == n);
  assign sts.div_busy = div_busy;
  assign sts.out_busy = out_valid && !out_ready;

endmodule
`default_nettype wire

FILE: rtl/idw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idw_ctrl
// Sequencer: walks a query over the table one point at a time.
// ----------------------------------------------------------------------------
module idw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_kind,
  output logic          in_ready,
  output idw_pkg::cmd_t cmd,
  input  idw_pkg::sts_t sts
);
  import idw_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_READ  = 16'h0002,
    S_DIFF  = 16'h0004,
    S_SQR   = 16'h0008,
    S_SUM   = 16'h0010,
    S_CHECK = 16'h0020,
    S_RDIV  = 16'h0040,
    S_WGT   = 16'h0080,
    S_MLO   = 16'h0100,
    S_MHI   = 16'h0200,
    S_MACC  = 16'h0400,
    S_FDIV  = 16'h0800,
    S_FWAIT = 16'h1000,
    S_FOUT  = 16'h2000,
    S_HOUT  = 16'h4000,
    S_EOUT  = 16'h8000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.q_latch = 1'b1;
            state_next  = sts.empty ? S_EOUT : S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_SQR;
      end
      S_SQR: begin
        cmd.sqr    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.hit) begin
          state_next = S_HOUT;
        end else if (sts.far) begin
          state_next = S_WGT;
        end else begin
          cmd.div_rcp = 1'b1;
          state_next  = S_RDIV;
        end
      end
      S_RDIV: begin
        if (!sts.div_busy) begin
          state_next = S_WGT;
        end
      end
      S_WGT: begin
        cmd.wgt    = 1'b1;
        state_next = S_MLO;
      end
      S_MLO: begin
        cmd.mlo    = 1'b1;
        state_next = S_MHI;
      end
      S_MHI: begin
        cmd.mhi    = 1'b1;
        state_next = S_MACC;
      end
      S_MACC: begin
        cmd.macc = 1'b1;
        if (sts.last) begin
          state_next = S_FDIV;
        end else begin
          cmd.nxt    = 1'b1;
          state_next = S_READ;
        end
      end
      S_FDIV: begin
        cmd.div_fin = 1'b1;
        state_next  = S_FWAIT;
      end
      S_FWAIT: begin
        if (!sts.div_busy) begin
          state_next = S_FOUT;
        end
      end
      S_FOUT: begin
        if (!sts.out_busy) begin
          cmd.res_fin = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_HOUT: begin
        if (!sts.out_busy) begin
          cmd.res_hit = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_EOUT: begin
        if (!sts.out_busy) begin
          cmd.res_empty = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_res_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.res_fin || cmd.res_hit || cmd.res_empty) |-> !sts.out_busy)
    else $error("result loaded over an untaken result");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_rcp || cmd.div_fin) |-> !sts.div_busy)
    else $error("divider restarted while busy");

  a_idle_no_div: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !sts.div_busy)
    else $error("input taken while divider busy");

  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_rcp || cmd.div_fin) |=> sts.div_busy)
    else $error("divider did not start");

endmodule
`default_nettype wire

FILE: rtl/idw_point_interpolator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idw_point_interpolator
// Inverse-distance (power 2) elevation lookup over a table of survey points.
// ----------------------------------------------------------------------------
//  channel  dir  handshake       beat contents
//  in_ch    in   valid/ready     kind, slot, coord_x, coord_y, height
//  out_ch   out  valid/ready     elevation_out, status
//  apb      in   psel/penable    point_count at byte address 0
//
//  A load beat is written on accept. A query reads, differences, squares,
//  sums and checks each point, runs the 64-step reciprocal division (not
//  for a far point), weights and accumulates; then come the 99-step final
//  division and result load. An exact hit exits after its distance check.
//  One item in flight; a finished result waits in the output register while
//  loads and the next query are taken. rst is synchronous; tables hold
//  no reset value.
// ----------------------------------------------------------------------------
module idw_point_interpolator #(
  parameter int MAX_POINTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  idw_in_if.sink      in_ch,
  idw_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import idw_pkg::*;

  logic [4:0] point_count;
  cmd_t       cmd;
  sts_t       sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_POINT_COUNT)) begin
      point_count <= pwdata[4:0];
    end
  end

  assign prdata = (paddr[2] == REG_POINT_COUNT) ? {27'b0, point_count} : 32'b0;

  idw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  idw_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .point_count   (point_count),
    .slot          (in_ch.slot),
    .coord_x       (in_ch.coord_x),
    .coord_y       (in_ch.coord_y),
    .height        (in_ch.height),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .elevation_out (out_ch.elevation_out),
    .status        (out_ch.status)
  );

endmodule
`default_nettype wire
